@@ hw/rtl/unsorted_max_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// unsorted max priority queue: assertion macros
// checks used by the datapath module umpq_dpath, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef UNSORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define UNSORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UMPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UMPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/umpq_pkg.sv @@
// ----------------------------------------------------------------------------
// umpq_pkg
// types, codes and defaults shared by the unsorted max priority queue
// ----------------------------------------------------------------------------
package umpq_pkg;

   // default number of entries held
   localparam int CAPACITY_DEFAULT = 128;

   // operation codes
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // request word
   typedef struct packed {
      logic        [1:0]  opcode;
      logic signed [31:0] in_data;
      logic signed [31:0] in_priority;
   } req_type;

   // response word
   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] out_data;
      logic signed [31:0] out_priority;
      logic        [7:0]  entry_count;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } entry_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic shift_init;
      logic shift;
      logic respond;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_scan;
      logic is_extract;
      logic scan_done;
      logic shift_done;
   } flags_type;

endpackage

@@ hw/rtl/umpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// umpq_ctrl
// sequencer for the queue: decode, maximum scan, gap closing and response
// ----------------------------------------------------------------------------
module umpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  umpq_pkg::flags_type  flags,
   output umpq_pkg::cmd_type    cmd
);
   import umpq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (flags.need_scan) begin
               state_in = S_SCAN;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (flags.scan_done) begin
               if (flags.is_extract) begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end else begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (flags.shift_done) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/umpq_dpath.sv @@
// ----------------------------------------------------------------------------
// umpq_dpath
// entry memory, fill count, scan pointer, best entry and response register
// ----------------------------------------------------------------------------
`include "unsorted_max_priority_queue_defines.svh"

module umpq_dpath #(
   parameter int CAPACITY = umpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  umpq_pkg::req_type    req_word,
   input  umpq_pkg::cmd_type    cmd,
   output umpq_pkg::flags_type  flags,
   output logic                 rsp_valid,
   output umpq_pkg::rsp_type    rsp_word
);
   import umpq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   entry_type              entry_store_ff [CAPACITY];
   req_type                req_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       ptr_ff;
   logic [CNT_W-1:0]       ptr_in;
   logic                   rvalid_ff;
   logic [IDX_W-1:0]       rd_pos_ff;
   entry_type              rd_data_ff;
   entry_type              best_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rd_en;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   logic                   ins_wr;
   logic                   shift_wr;
   logic                   best_upd;
   logic                   is_full;
   logic                   is_empty;

   assign is_full  = (count_ff == CAP_CNT);
   assign is_empty = (count_ff == '0);

   // status towards the controller
   assign flags.need_scan  = ((req_ff.opcode == OP_EXTRACT) || (req_ff.opcode == OP_PEEK))
                             && !is_empty;
   assign flags.is_extract = (req_ff.opcode == OP_EXTRACT);
   assign flags.scan_done  = (ptr_ff == count_ff) && !rvalid_ff;
   assign flags.shift_done = (ptr_ff >= count_ff) && !rvalid_ff;

   // read pointer walks the filled entries during scan and shift
   assign rd_en = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.shift_init) begin
         ptr_in = CNT_W'(best_idx_ff) + CNT_W'(1);
      end else if (rd_en) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   // first entry or a strictly larger priority takes the lead, so ties keep the earliest
   assign best_upd = cmd.scan && rvalid_ff &&
                     ((rd_pos_ff == '0) || ($signed(rd_data_ff.prio) > $signed(best_ff.prio)));

   // write port: append on insert, move one place down while closing the gap
   assign ins_wr   = cmd.respond && (req_ff.opcode == OP_INSERT) && !is_full;
   assign shift_wr = cmd.shift && rvalid_ff;
   assign wr_en    = ins_wr || shift_wr;

   always_comb begin
      if (shift_wr) begin
         wr_addr = rd_pos_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end else begin
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = '{data: req_ff.in_data, prio: req_ff.in_priority};
      end
   end

   // response word and new fill count
   always_comb begin
      count_in              = count_ff;
      rsp_in.status         = STAT_OK;
      rsp_in.out_data       = '0;
      rsp_in.out_priority   = '0;
      case (req_ff.opcode)
         OP_INSERT: begin
            if (is_full) begin
               rsp_in.status = STAT_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_EXTRACT: begin
            if (is_empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.out_data     = best_ff.data;
               rsp_in.out_priority = best_ff.prio;
               count_in            = count_ff - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (is_empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.out_data     = best_ff.data;
               rsp_in.out_priority = best_ff.prio;
            end
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase
      rsp_in.entry_count = 8'(count_in);
   end

   // entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[ptr_ff[IDX_W-1:0]];
         rd_pos_ff  <= ptr_ff[IDX_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rvalid_ff    <= rd_en;
         rsp_valid_ff <= cmd.respond;
         if (cmd.respond) begin
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (best_upd) begin
         best_ff     <= rd_data_ff;
         best_idx_ff <= rd_pos_ff;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `UMPQ_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CAP_CNT, "fill count beyond capacity")
   `UMPQ_ASSERT_SAME(a_shift_pos, shift_wr, rd_pos_ff != '0, "gap closing writes below entry zero")
   `UMPQ_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff, "back to back response strobes")
   `UMPQ_ASSERT_NEXT(a_extract_count, cmd.respond && (req_ff.opcode == OP_EXTRACT) && !is_empty,
      count_ff == $past(count_ff) - CNT_W'(1), "extract did not drop the fill count")

endmodule

@@ hw/rtl/unsorted_max_priority_queue.sv @@
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue
// max priority queue kept as an unsorted array in insertion order
//
//   channel   ports                      handshake
//   request   req_word                   taken when start high and busy low
//   response  rsp_word                   one cycle strobe on rsp_valid
//
// insert, the unused opcode and an empty queue: no scan; S_EXEC issues the response into the response register
// peek: the scan reads the filled entries, one entry read a cycle, to find the maximum
// extract: the scan as for peek, then the gap behind the maximum is
//   closed one entry a cycle through the one read port and the one write port of the memory
// synchronous reset empties the queue; the memory is not cleared
// busy stays high until the response is issued; responses cannot be stalled
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue #(
   parameter int CAPACITY = umpq_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  umpq_pkg::req_type  req_word,
   output logic               rsp_valid,
   output umpq_pkg::rsp_type  rsp_word
);
   import umpq_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   // sequencer
   umpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   // storage and response
   umpq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
